### hdl/lpfe_pkg.sv
`default_nettype none

package lpfe_pkg;

   // Field widths
   localparam int unsigned IndexW = 10;
   localparam int unsigned ColorW = 8;
   localparam int unsigned AddrW  = 16;
   localparam int unsigned CountW = 11;
   localparam int unsigned ModeW  = 3;
   localparam int unsigned OrderW = 3;
   localparam int unsigned SeqW   = 5;   // write counter, up to 32 writes per item
   localparam int unsigned CsrAddrW = 5;
   localparam int unsigned CsrDataW = 32;

   // Strip limit and queue default
   localparam int unsigned MaxPixels  = 1024;
   localparam int unsigned QueueDepth = 2;

   // Encoding modes
   localparam logic [ModeW-1:0] ModeRtzRgb    = 3'd0;
   localparam logic [ModeW-1:0] ModeRtzRgbw   = 3'd1;
   localparam logic [ModeW-1:0] ModeBrightRgb = 3'd2;
   localparam logic [ModeW-1:0] ModePlainRgb  = 3'd3;
   localparam logic [ModeW-1:0] ModeFlagBgr   = 3'd4;

   // Three-colour orders
   localparam logic [OrderW-1:0] OrderRbg = 3'd1;
   localparam logic [OrderW-1:0] OrderGrb = 3'd2;
   localparam logic [OrderW-1:0] OrderGbr = 3'd3;
   localparam logic [OrderW-1:0] OrderBrg = 3'd4;
   localparam logic [OrderW-1:0] OrderBgr = 3'd5;

   // Register indexes
   localparam logic [2:0] RegMode       = 3'd0;
   localparam logic [2:0] RegOrder      = 3'd1;
   localparam logic [2:0] RegOneCode    = 3'd2;
   localparam logic [2:0] RegZeroCode   = 3'd3;
   localparam logic [2:0] RegBrightness = 3'd4;
   localparam logic [2:0] RegPixelCount = 3'd5;

   // Register reset values
   localparam logic [ModeW-1:0]  ModeReset       = ModeRtzRgb;
   localparam logic [OrderW-1:0] OrderReset      = OrderGrb;
   localparam logic [7:0]        OneCodeReset    = 8'd248;
   localparam logic [7:0]        ZeroCodeReset   = 8'd192;
   localparam logic [7:0]        BrightnessReset = 8'd255;
   localparam logic [CountW-1:0] PixelCountReset = 11'd1024;

   // Flag header base
   localparam logic [7:0] FlagBase = 8'hC0;

   typedef struct packed {
      logic [IndexW-1:0] pixel_index;
      logic [ColorW-1:0] red;
      logic [ColorW-1:0] green;
      logic [ColorW-1:0] blue;
      logic [ColorW-1:0] white;
   } req_type;

   typedef struct packed {
      logic [AddrW-1:0]  byte_address;
      logic [7:0]        byte_value;
      logic              last_write;
   } rsp_type;

   typedef struct packed {
      logic [ModeW-1:0]  encoding_mode;
      logic [OrderW-1:0] color_order;
      logic [7:0]        one_code;
      logic [7:0]        zero_code;
      logic [7:0]        brightness_byte;
      logic [CountW-1:0] pixel_count;
   } cfg_type;

   // One classified item: bytes in send order, byte 0 first
   typedef struct packed {
      logic [AddrW-1:0]      base;
      logic [3:0][7:0]       bytes;
      logic                  rtz;
      logic [SeqW-1:0]       last_seq;
   } desc_type;

endpackage

`default_nettype wire

### hdl/lpfe_front.sv
`default_nettype none

module lpfe_front (
   input  wire  logic               req_valid,
   output       logic               req_stall,
   input  wire  lpfe_pkg::req_type  req_data,
   input  wire  lpfe_pkg::cfg_type  cfg,
   input  wire  logic               queue_full,
   output       logic               push_valid,
   output       lpfe_pkg::desc_type push_data
);

   logic                     in_range;
   logic                     mode_ok;
   logic [lpfe_pkg::AddrW-1:0] idx_w;
   logic [7:0]               r, g, b;
   logic [7:0]               flag;

   assign r     = req_data.red;
   assign g     = req_data.green;
   assign b     = req_data.blue;
   assign idx_w = lpfe_pkg::AddrW'(req_data.pixel_index);

   // Drop pixels beyond the strip
   assign in_range = ({1'b0, req_data.pixel_index} < cfg.pixel_count)
                  && (32'(req_data.pixel_index) < lpfe_pkg::MaxPixels);

   assign flag = lpfe_pkg::FlagBase | {2'b00, ~b[7:6], ~g[7:6], ~r[7:6]};

   // Classify by mode: base address, byte sequence and write count
   always_comb begin
      push_data = '0;
      mode_ok   = 1'b1;
      case (cfg.encoding_mode)
         lpfe_pkg::ModeRtzRgb: begin
            push_data.base     = (idx_w << 4) + (idx_w << 3) + 16'd1;
            push_data.rtz      = 1'b1;
            push_data.last_seq = 5'd23;
            case (cfg.color_order)
               lpfe_pkg::OrderRbg: push_data.bytes = {8'h00, g, b, r};
               lpfe_pkg::OrderGrb: push_data.bytes = {8'h00, b, r, g};
               lpfe_pkg::OrderGbr: push_data.bytes = {8'h00, r, b, g};
               lpfe_pkg::OrderBrg: push_data.bytes = {8'h00, g, r, b};
               lpfe_pkg::OrderBgr: push_data.bytes = {8'h00, r, g, b};
               default:            push_data.bytes = {8'h00, b, g, r};
            endcase
         end
         lpfe_pkg::ModeRtzRgbw: begin
            push_data.base     = (idx_w << 5) + 16'd1;
            push_data.rtz      = 1'b1;
            push_data.last_seq = 5'd31;
            push_data.bytes    = {req_data.white, b, r, g};
         end
         lpfe_pkg::ModeBrightRgb: begin
            push_data.base     = (idx_w << 2) + 16'd4;
            push_data.last_seq = 5'd3;
            push_data.bytes    = {b, g, r, cfg.brightness_byte};
         end
         lpfe_pkg::ModePlainRgb: begin
            push_data.base     = (idx_w << 1) + idx_w;
            push_data.last_seq = 5'd2;
            push_data.bytes    = {8'h00, b, g, r};
         end
         lpfe_pkg::ModeFlagBgr: begin
            push_data.base     = (idx_w << 2) + 16'd4;
            push_data.last_seq = 5'd3;
            push_data.bytes    = {r, g, b, flag};
         end
         default: mode_ok = 1'b0;
      endcase
   end

   // Hold the input while the queue is full
   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full && in_range && mode_ok;

endmodule

`default_nettype wire

### hdl/lpfe_fifo.sv
`default_nettype none

module lpfe_fifo #(
   parameter int unsigned DEPTH = lpfe_pkg::QueueDepth
) (
   input  wire  logic               clock,
   input  wire  logic               reset,
   input  wire  logic               push_valid,
   input  wire  lpfe_pkg::desc_type push_data,
   output       logic               full,
   input  wire  logic               pop,
   output       logic               head_valid,
   output       lpfe_pkg::desc_type head_data
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   lpfe_pkg::desc_type slots_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_pop;

   assign full       = (count_ff == CntFull);
   assign head_valid = (count_ff != '0);
   assign head_data  = slots_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hdl/lpfe_back.sv
`default_nettype none

module lpfe_back (
   input  wire  logic               clock,
   input  wire  logic               reset,
   input  wire  lpfe_pkg::cfg_type  cfg,
   input  wire  logic               head_valid,
   input  wire  lpfe_pkg::desc_type head_data,
   output       logic               pop,
   output       logic               rsp_valid,
   input  wire  logic               rsp_stall,
   output       lpfe_pkg::rsp_type  rsp_data
);

   lpfe_pkg::desc_type          desc_ff, desc_in;
   logic [lpfe_pkg::SeqW-1:0]   seq_ff, seq_in;
   logic                        busy_ff, busy_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   lpfe_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   logic                        out_free;
   logic                        at_last;
   logic [7:0]                  cur_byte;
   logic                        cur_bit;
   lpfe_pkg::rsp_type           gen;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign at_last  = (seq_ff == desc_ff.last_seq);
   assign pop      = head_valid && (!busy_ff || (out_free && at_last));

   // Form the current write
   always_comb begin
      if (desc_ff.rtz) begin
         cur_byte = desc_ff.bytes[seq_ff[4:3]];
         cur_bit  = cur_byte[~seq_ff[2:0]];
         gen.byte_value = cur_bit ? cfg.one_code : cfg.zero_code;
      end else begin
         cur_byte = desc_ff.bytes[seq_ff[1:0]];
         cur_bit  = 1'b0;
         gen.byte_value = cur_byte;
      end
      gen.byte_address = desc_ff.base + lpfe_pkg::AddrW'(seq_ff);
      gen.last_write   = at_last;
   end

   // Advance the sequencer, load the next item when this one ends
   always_comb begin
      desc_in      = desc_ff;
      seq_in       = seq_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = busy_ff;
         rsp_data_in  = gen;
      end
      if (pop) begin
         desc_in = head_data;
         seq_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff && out_free) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            seq_in = seq_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      seq_ff      <= seq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### hdl/led_pixel_frame_encoder_core.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    lpfe_pkg::req_type (one pixel)
// rsp       out        rsp_valid/stall    lpfe_pkg::rsp_type (one buffer write)
// csr       in/out     psel/penable       six registers at byte address 4*i
//
// Writes leave at one per cycle from the single result register while rsp_stall is
// low: 24 writes for a three-colour rtz pixel, 32 for four-colour rtz, 4 in modes 2 and 4, 3 in mode 3.
// A dropped pixel (index out of range or unused mode) produces no writes.
// Reset is synchronous and returns the registers to their defaults; there is no
// clearing pass. The queue of QUEUE_DEPTH items lets the input run ahead of a
// stalled result channel; req_stall rises only when that queue is full.

module led_pixel_frame_encoder_core #(
   parameter int unsigned QUEUE_DEPTH = lpfe_pkg::QueueDepth
) (
   input  wire  logic                            clock,
   input  wire  logic                            reset,
   input  wire  logic                            req_valid,
   output       logic                            req_stall,
   input  wire  lpfe_pkg::req_type               req_data,
   output       logic                            rsp_valid,
   input  wire  logic                            rsp_stall,
   output       lpfe_pkg::rsp_type               rsp_data,
   input  wire  logic                            psel,
   input  wire  logic                            penable,
   input  wire  logic                            pwrite,
   input  wire  logic [lpfe_pkg::CsrAddrW-1:0]   paddr,
   input  wire  logic [lpfe_pkg::CsrDataW-1:0]   pwdata,
   output       logic [lpfe_pkg::CsrDataW-1:0]   prdata,
   output       logic                            pready
);

   lpfe_pkg::cfg_type  cfg_ff, cfg_in;
   logic               cfg_write;
   logic [2:0]         reg_sel;
   logic               push_valid;
   lpfe_pkg::desc_type push_data;
   logic               queue_full;
   logic               pop;
   logic               head_valid;
   lpfe_pkg::desc_type head_data;

   assign pready    = 1'b1;
   assign reg_sel   = paddr[4:2];
   assign cfg_write = psel && penable && pwrite;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_sel)
            lpfe_pkg::RegMode:       cfg_in.encoding_mode   = pwdata[2:0];
            lpfe_pkg::RegOrder:      cfg_in.color_order     = pwdata[2:0];
            lpfe_pkg::RegOneCode:    cfg_in.one_code        = pwdata[7:0];
            lpfe_pkg::RegZeroCode:   cfg_in.zero_code       = pwdata[7:0];
            lpfe_pkg::RegBrightness: cfg_in.brightness_byte = pwdata[7:0];
            lpfe_pkg::RegPixelCount: cfg_in.pixel_count     = pwdata[10:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.encoding_mode   <= lpfe_pkg::ModeReset;
         cfg_ff.color_order     <= lpfe_pkg::OrderReset;
         cfg_ff.one_code        <= lpfe_pkg::OneCodeReset;
         cfg_ff.zero_code       <= lpfe_pkg::ZeroCodeReset;
         cfg_ff.brightness_byte <= lpfe_pkg::BrightnessReset;
         cfg_ff.pixel_count     <= lpfe_pkg::PixelCountReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the selected register
   always_comb begin
      case (reg_sel)
         lpfe_pkg::RegMode:       prdata = 32'(cfg_ff.encoding_mode);
         lpfe_pkg::RegOrder:      prdata = 32'(cfg_ff.color_order);
         lpfe_pkg::RegOneCode:    prdata = 32'(cfg_ff.one_code);
         lpfe_pkg::RegZeroCode:   prdata = 32'(cfg_ff.zero_code);
         lpfe_pkg::RegBrightness: prdata = 32'(cfg_ff.brightness_byte);
         lpfe_pkg::RegPixelCount: prdata = 32'(cfg_ff.pixel_count);
         default:                 prdata = '0;
      endcase
   end

   lpfe_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   lpfe_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   lpfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
